### rtl/cflr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflr_pkg
// Shared types and constants of the column framebuffer line rasterizer.
// ----------------------------------------------------------------------------
package cflr_pkg;

    localparam int COORD_W = 8;
    localparam int COL_W   = 64;
    localparam int ERR_W   = COORD_W + 3;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

endpackage

### rtl/cflr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflr_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cflr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/column_framebuffer_line_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_framebuffer_line_raster
// Monochrome framebuffer, one word per column, with pixel, line, clear and
// read commands; lines are walked with an integer error term.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  command   in         start / busy     kind start_x start_y end_x end_y
//                                        pixel_value
//  result    out        done (1 cycle)   column_bits read_valid
//
//  pixel, line: walked in ST_WALK, one column read-modify-write per cycle
//  through the single RAM read port, then finished in ST_DRAIN.
//  clear: column valid flags dropped without going busy; read: ST_READ.
//  done follows the last cycle of a command; busy is low on that cycle.
//  reset clears all control state and the column valid flags, so the
//  frame reads as zero without a clearing pass. results cannot be stalled.
// ----------------------------------------------------------------------------
module column_framebuffer_line_raster #(
    parameter int DISPLAY_WIDTH  = 256,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  cflr_pkg::kind_t               kind,
    input  logic [cflr_pkg::COORD_W-1:0]  start_x,
    input  logic [cflr_pkg::COORD_W-1:0]  start_y,
    input  logic [cflr_pkg::COORD_W-1:0]  end_x,
    input  logic [cflr_pkg::COORD_W-1:0]  end_y,
    input  logic                          pixel_value,
    output logic                          done,
    output logic [cflr_pkg::COL_W-1:0]    column_bits,
    output logic                          read_valid
);

    import cflr_pkg::*;

    localparam int AW = $clog2(DISPLAY_WIDTH);
    localparam int HW = $clog2(DISPLAY_HEIGHT);
    localparam logic [COORD_W:0] WIDTH_LIM  = (COORD_W + 1)'(DISPLAY_WIDTH);
    localparam logic [COORD_W:0] HEIGHT_LIM = (COORD_W + 1)'(DISPLAY_HEIGHT);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_READ  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // line walker
    logic [COORD_W-1:0]      cx_reg, cx_next, cy_reg, cy_next;
    logic [COORD_W-1:0]      x1_reg, x1_next, y1_reg, y1_next;
    logic [COORD_W-1:0]      dx_reg, dx_next, dy_reg, dy_next;
    logic                    sxn_reg, sxn_next, syn_reg, syn_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic                    on_reg, on_next;

    // write-back stage
    logic          s1_valid_reg, s1_valid_next;
    logic [AW-1:0] s1_col_reg, s1_col_next;
    logic [HW-1:0] s1_idx_reg, s1_idx_next;
    logic          s1_hit_reg, s1_hit_next;
    logic          s1_set_reg, s1_set_next;
    logic          s1_stored_reg, s1_stored_next;

    // last write, forwarded to a back-to-back access of the same column
    logic                      fwd_valid_reg, fwd_valid_next;
    logic [AW-1:0]             fwd_col_reg, fwd_col_next;
    logic [DISPLAY_HEIGHT-1:0] fwd_data_reg, fwd_data_next;

    logic [DISPLAY_WIDTH-1:0] col_valid_reg, col_valid_next;

    logic             done_reg, done_next;
    logic             read_valid_reg, read_valid_next;
    logic [COL_W-1:0] column_bits_reg, column_bits_next;

    logic                      accept;
    logic                      at_end;
    logic signed [ERR_W:0]     e2, dx_e, dy_e;
    logic                      x_step, y_step;
    logic [AW-1:0]             rd_col;
    logic [COORD_W-1:0]        iss_x, iss_y;
    logic                      ram_we;
    logic [DISPLAY_HEIGHT-1:0] ram_rdata, base_word, bit_mask, wr_word;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign at_end = (cx_reg == x1_reg) && (cy_reg == y1_reg);
    assign e2     = {err_reg, 1'b0};
    assign dx_e   = $signed({{(ERR_W + 1 - COORD_W){1'b0}}, dx_reg});
    assign dy_e   = $signed({{(ERR_W + 1 - COORD_W){1'b0}}, dy_reg});
    assign x_step = (e2 > -dy_e);
    assign y_step = (e2 < dx_e);

    assign iss_x  = (state_reg == ST_IDLE) ? start_x : cx_reg;
    assign iss_y  = (state_reg == ST_IDLE) ? start_y : cy_reg;
    assign rd_col = iss_x[AW-1:0];

    always_comb
    begin
        if (fwd_valid_reg && (fwd_col_reg == s1_col_reg))
        begin
            base_word = fwd_data_reg;
        end
        else if (s1_stored_reg)
        begin
            base_word = ram_rdata;
        end
        else
        begin
            base_word = '0;
        end
    end

    assign bit_mask = {{(DISPLAY_HEIGHT - 1){1'b0}}, 1'b1} << s1_idx_reg;
    assign wr_word  = s1_set_reg ? (base_word | bit_mask) : (base_word & ~bit_mask);
    assign ram_we   = s1_valid_reg && s1_hit_reg;

    cflr_ram #(
        .WIDTH (DISPLAY_HEIGHT),
        .DEPTH (DISPLAY_WIDTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (wr_word),
        .raddr (rd_col),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        x1_next          = x1_reg;
        y1_next          = y1_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        sxn_next         = sxn_reg;
        syn_next         = syn_reg;
        err_next         = err_reg;
        on_next          = on_reg;
        col_valid_next   = col_valid_reg;
        fwd_valid_next   = fwd_valid_reg;
        fwd_col_next     = fwd_col_reg;
        fwd_data_next    = fwd_data_reg;
        done_next        = 1'b0;
        read_valid_next  = 1'b0;
        column_bits_next = '0;

        // issue stage, used by reads and walker steps
        s1_valid_next  = (state_reg == ST_WALK);
        s1_col_next    = rd_col;
        s1_idx_next    = iss_y[HW-1:0];
        s1_hit_next    = ({1'b0, iss_x} < WIDTH_LIM) &&
                         ((state_reg == ST_IDLE) || ({1'b0, iss_y} < HEIGHT_LIM));
        s1_stored_next = col_valid_reg[rd_col];
        s1_set_next    = on_reg;

        if (ram_we)
        begin
            col_valid_next[s1_col_reg] = 1'b1;
            fwd_valid_next             = 1'b1;
            fwd_col_next               = s1_col_reg;
            fwd_data_next              = wr_word;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_PIXEL, KIND_LINE:
                        begin
                            cx_next  = start_x;
                            cy_next  = start_y;
                            sxn_next = !(start_x < end_x);
                            syn_next = !(start_y < end_y);
                            on_next  = (kind == KIND_LINE) ? 1'b1 : pixel_value;
                            if (kind == KIND_LINE)
                            begin
                                x1_next = end_x;
                                y1_next = end_y;
                                dx_next = (end_x > start_x) ? end_x - start_x
                                                            : start_x - end_x;
                                dy_next = (end_y > start_y) ? end_y - start_y
                                                            : start_y - end_y;
                            end
                            else
                            begin
                                x1_next = start_x;
                                y1_next = start_y;
                                dx_next = '0;
                                dy_next = '0;
                            end
                            err_next   = $signed({{(ERR_W - COORD_W){1'b0}}, dx_next})
                                       - $signed({{(ERR_W - COORD_W){1'b0}}, dy_next});
                            state_next = ST_WALK;
                        end
                        KIND_CLEAR:
                        begin
                            col_valid_next = '0;
                            fwd_valid_next = 1'b0;
                            done_next      = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (at_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    if (x_step)
                    begin
                        cx_next = sxn_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
                    end
                    if (y_step)
                    begin
                        cy_next = syn_reg ? cy_reg - 1'b1 : cy_reg + 1'b1;
                    end
                    err_next = err_reg
                             - (x_step ? dy_e[ERR_W-1:0] : '0)
                             + (y_step ? dx_e[ERR_W-1:0] : '0);
                end
            end
            ST_DRAIN:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                done_next       = 1'b1;
                read_valid_next = 1'b1;
                if (s1_hit_reg)
                begin
                    column_bits_next = COL_W'(base_word);
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            col_valid_reg  <= '0;
            done_reg       <= 1'b0;
            read_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            s1_valid_reg   <= s1_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            col_valid_reg  <= col_valid_next;
            done_reg       <= done_next;
            read_valid_reg <= read_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg          <= cx_next;
        cy_reg          <= cy_next;
        x1_reg          <= x1_next;
        y1_reg          <= y1_next;
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        sxn_reg         <= sxn_next;
        syn_reg         <= syn_next;
        err_reg         <= err_next;
        on_reg          <= on_next;
        s1_col_reg      <= s1_col_next;
        s1_idx_reg      <= s1_idx_next;
        s1_hit_reg      <= s1_hit_next;
        s1_set_reg      <= s1_set_next;
        s1_stored_reg   <= s1_stored_next;
        fwd_col_reg     <= fwd_col_next;
        fwd_data_reg    <= fwd_data_next;
        column_bits_reg <= column_bits_next;
    end

    assign done        = done_reg;
    assign read_valid  = read_valid_reg;
    assign column_bits = column_bits_reg;

`ifndef ASSERT_OFF
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("framebuffer written while idle");

    a_clear_drops_all: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_CLEAR)) |=> (col_valid_reg == '0) && done)
        else $error("clear did not drop every column");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind != KIND_CLEAR)) |=> busy)
        else $error("command accepted without going busy");

    a_bits_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (column_bits != '0) |-> (read_valid && done))
        else $error("column data shown outside a read result");
`endif

endmodule
